// ----- sv/vcrf_pkg.sv -----
// ----------------------------------------------------------------------------
// vcrf_pkg
// Shared constants and types of the video chip register file.
// ----------------------------------------------------------------------------
package vcrf_pkg;

	localparam int CHAR_BYTES_DEF    = 8192;
	localparam int ATTR_BYTES_DEF    = 4096;
	localparam int SPRITE_COUNT_DEF  = 64;
	localparam int COLOR_ENTRIES_DEF = 256;

	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	localparam logic [7:0] LINE_MIN      = 8'd152;
	localparam logic [7:0] LINE_RESET    = 8'd198;
	localparam logic [7:0] GROUP_RST_KEY = 8'h52;
	localparam logic [7:0] PORT_RSVD_VAL = 8'h3f;

	// Which memory a read came from, carried with the request
	typedef enum logic [2:0] {
		SRC_REG   = 3'd0,
		SRC_CHAR  = 3'd1,
		SRC_ATTR  = 3'd2,
		SRC_SPR   = 3'd3,
		SRC_CODE  = 3'd4,
		SRC_COLLO = 3'd5,
		SRC_COLHI = 3'd6
	} src_t;

endpackage

// ----- sv/vcrf_if.sv -----
// ----------------------------------------------------------------------------
// vcrf_req_if / vcrf_rsp_if / vcrf_cfg_if
// Valid/ready channels of the video chip register file.
// ----------------------------------------------------------------------------
interface vcrf_req_if;
	logic       valid;
	logic       ready;
	logic       op;
	logic [13:0] address;
	logic [7:0] write_data;
	logic       privileged;
	logic [9:0] raster_hcount;
	logic [7:0] raster_vcount;
	logic       vblank_now;
	logic       char_overflow;
	modport source (output valid, op, address, write_data, privileged, raster_hcount,
		raster_vcount, vblank_now, char_overflow, input ready);
	modport sink (input valid, op, address, write_data, privileged, raster_hcount,
		raster_vcount, vblank_now, char_overflow, output ready);
endinterface

interface vcrf_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;
	modport source (output valid, read_data, input ready);
	modport sink (input valid, read_data, output ready);
endinterface

interface vcrf_cfg_if;
	logic valid;
	logic ready;
	logic color_model;
	modport source (output valid, color_model, input ready);
	modport sink (input valid, color_model, output ready);
endinterface

// ----- sv/video_chip_register_file_core.sv -----
// ----------------------------------------------------------------------------
// video_chip_register_file_core
// Bus decode and register/memory file of a handheld video chip.
// ----------------------------------------------------------------------------
//  channel  dir  handshake    payload
//  req      in   valid/ready  op, address, write_data, privileged, raster, status
//  rsp      out  valid/ready  read_data (reads only)
//  cfg      in   valid/ready  color_model
//
// One request per cycle while the response is not stalled: decode and memory read in
// the accept cycle, byte out from the result register next cycle; writes land in the decode cycle.
// After reset a clearing pass sweeps all memories, one address a cycle, over the
// address range of the larger of CHAR_BYTES and ATTR_BYTES; no request is taken
// meanwhile.
// A stalled response holds the pipe; a request is taken while the result
// register is empty or being drained and no clearing pass is running.
// ----------------------------------------------------------------------------
module video_chip_register_file_core #(
	parameter int CHAR_BYTES    = vcrf_pkg::CHAR_BYTES_DEF,
	parameter int ATTR_BYTES    = vcrf_pkg::ATTR_BYTES_DEF,
	parameter int SPRITE_COUNT  = vcrf_pkg::SPRITE_COUNT_DEF,
	parameter int COLOR_ENTRIES = vcrf_pkg::COLOR_ENTRIES_DEF
) (
	input logic clk,
	input logic arst_n,
	vcrf_req_if.sink   req,
	vcrf_rsp_if.source rsp,
	vcrf_cfg_if.sink   cfg
);

	localparam int CW = $clog2(CHAR_BYTES);
	localparam int AW = $clog2(ATTR_BYTES);
	localparam int SPR_BYTES = SPRITE_COUNT * 4;
	localparam int SW = $clog2(SPR_BYTES);
	localparam int KW = $clog2(SPRITE_COUNT);
	localparam int LW = $clog2(COLOR_ENTRIES);
	// sprite and color memories must be no deeper than the larger character/attribute size (not checked here)
	localparam int CLR_BYTES = (CHAR_BYTES > ATTR_BYTES) ? CHAR_BYTES : ATTR_BYTES;
	localparam int XW = $clog2(CLR_BYTES);

	// clear sweep
	logic [XW:0] clr_q;
	logic        clearing;
	assign clearing = !clr_q[XW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (clearing) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// config register
	logic cm_q;
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cm_q <= 1'b1;
		end else if (cfg.valid) begin
			cm_q <= cfg.color_model;
		end
	end

	// pipeline control
	logic v_s1, acc, adv;
	assign adv = !v_s1 || rsp.ready;
	assign req.ready = adv && !clearing;
	assign acc = req.valid && req.ready;
	assign rsp.valid = v_s1;

	// decode
	logic [15:0] ea;
	logic [7:0]  d;
	logic        wr, rd;
	assign ea = {2'b10, req.address};
	assign d  = req.write_data;
	assign wr = acc && req.op == vcrf_pkg::OP_WRITE;
	assign rd = acc && req.op == vcrf_pkg::OP_READ;

	logic in_col, in_spr, in_codew, in_coder, in_attr, in_char;
	assign in_col   = ea >= 16'h8200 && ea <= 16'h83ff && cm_q;
	assign in_spr   = ea >= 16'h8800 && ea <= 16'h88ff;
	assign in_codew = ea >= 16'h8c00 && ea <= 16'h8cff && cm_q;
	assign in_coder = ea >= 16'h8c00 && ea <= 16'h8c3f && cm_q;
	assign in_attr  = ea >= 16'h9000 && ea <= 16'h9fff;
	assign in_char  = ea >= 16'ha000;

	logic [8:0] coff;
	assign coff = ea[8:0];

	// memory ports
	logic [7:0]  char_rd, attr_rd, spr_rd;
	logic [3:0]  code_rd;
	logic [3:0]  colhi_rd;
	logic [7:0]  collo_rd;
	logic [CW-1:0] char_wa;
	logic [AW-1:0] attr_wa;
	logic [SW-1:0] spr_wa;
	logic [KW-1:0] code_wa;
	logic [LW-1:0] col_wa;
	logic [7:0]  wd8;
	logic [3:0]  wd4;
	logic        char_we, attr_we, spr_we, code_we, collo_we, colhi_we;

	assign wd8 = clearing ? 8'd0 : d;
	assign wd4 = clearing ? 4'd0 : d[3:0];
	assign char_wa = clearing ? clr_q[CW-1:0] : req.address[CW-1:0];
	assign attr_wa = clearing ? clr_q[AW-1:0] : req.address[AW-1:0];
	assign spr_wa  = clearing ? clr_q[SW-1:0] : req.address[SW-1:0];
	assign code_wa = clearing ? clr_q[KW-1:0] : req.address[KW-1:0];
	assign col_wa  = clearing ? clr_q[LW-1:0] : coff[LW:1];
	assign char_we  = clearing || (wr && in_char);
	assign attr_we  = clearing || (wr && in_attr);
	assign spr_we   = clearing || (wr && in_spr);
	assign code_we  = clearing || (wr && in_codew);
	assign collo_we = clearing || (wr && in_col && !coff[0]);
	assign colhi_we = clearing || (wr && in_col && coff[0]);

	vcrf_ram #(.WIDTH(8), .DEPTH(CHAR_BYTES)) u_char (.clk, .we(char_we), .waddr(char_wa),
		.wdata(wd8), .re(rd), .raddr(req.address[CW-1:0]), .rdata(char_rd));
	vcrf_ram #(.WIDTH(8), .DEPTH(ATTR_BYTES)) u_attr (.clk, .we(attr_we), .waddr(attr_wa),
		.wdata(wd8), .re(rd), .raddr(req.address[AW-1:0]), .rdata(attr_rd));
	vcrf_ram #(.WIDTH(8), .DEPTH(SPR_BYTES)) u_spr (.clk, .we(spr_we), .waddr(spr_wa),
		.wdata(wd8), .re(rd), .raddr(req.address[SW-1:0]), .rdata(spr_rd));
	vcrf_ram #(.WIDTH(4), .DEPTH(SPRITE_COUNT)) u_code (.clk, .we(code_we), .waddr(code_wa),
		.wdata(wd4), .re(rd), .raddr(req.address[KW-1:0]), .rdata(code_rd));
	vcrf_ram #(.WIDTH(8), .DEPTH(COLOR_ENTRIES)) u_collo (.clk, .we(collo_we),
		.waddr(col_wa), .wdata(wd8), .re(rd), .raddr(coff[LW:1]), .rdata(collo_rd));
	vcrf_ram #(.WIDTH(4), .DEPTH(COLOR_ENTRIES)) u_colhi (.clk, .we(colhi_we),
		.waddr(col_wa), .wdata(wd4), .re(rd), .raddr(coff[LW:1]), .rdata(colhi_rd));

	// registers
	logic [1:0] irq_q;
	logic [7:0] win_q [4];
	logic [7:0] line_q;
	logic [3:0] wcn_q;
	logic [7:0] scr_q [6];
	logic       pri_q;
	logic [2:0] pal_q [24];
	logic [7:0] bg_q;
	logic [7:0] led_q [2];
	logic       dac_q;
	logic       in_pal;
	logic [4:0] pal_i;
	assign in_pal = ea >= 16'h8100 && ea <= 16'h8117;
	assign pal_i  = ea[4:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			irq_q  <= '0;
			line_q <= vcrf_pkg::LINE_RESET;
			wcn_q  <= '0;
			pri_q  <= 1'b0;
			bg_q   <= '0;
			dac_q  <= 1'b0;
			for (int i = 0; i < 4; i++) win_q[i] <= '0;
			for (int i = 0; i < 6; i++) scr_q[i] <= '0;
			for (int i = 0; i < 24; i++) pal_q[i] <= '0;
			led_q[0] <= '0;
			led_q[1] <= '0;
		end else if (wr && !in_col && !in_spr && !in_codew && !in_attr && !in_char) begin
			if (in_pal) begin
				if (pal_i[1:0] != 2'd0) pal_q[pal_i] <= d[2:0];
			end else if (ea >= 16'h8002 && ea <= 16'h8005) begin
				win_q[2'(ea - 16'h8002)] <= d;
			end else if (ea >= 16'h8032 && ea <= 16'h8035) begin
				scr_q[3'(ea - 16'h8030)] <= d;
			end else begin
				unique case (ea)
					16'h8000: irq_q <= d[7:6];
					16'h8006: line_q <= (d < vcrf_pkg::LINE_MIN) ? vcrf_pkg::LINE_MIN : d;
					16'h8012: wcn_q <= {d[7], d[2:0]};
					16'h8020: scr_q[0] <= d;
					16'h8021: scr_q[1] <= d;
					16'h8030: pri_q <= d[7];
					16'h8118: if (cm_q) bg_q <= d;
					16'h8400: led_q[0] <= {d[7:3], led_q[0][2:0]};
					16'h8402: led_q[1] <= d;
					16'h87e0: if (d == vcrf_pkg::GROUP_RST_KEY) begin
						irq_q  <= '0;
						line_q <= vcrf_pkg::LINE_RESET;
						pri_q  <= 1'b0;
					end
					16'h87e2: if (cm_q && req.privileged) dac_q <= d[7];
					default: ;
				endcase
			end
		end
	end

	// register read mux
	logic [7:0] reg_rd;
	always_comb begin
		reg_rd = 8'd0;
		if (in_pal) begin
			reg_rd = {5'd0, pal_q[pal_i]};
		end else if (ea >= 16'h8002 && ea <= 16'h8005) begin
			reg_rd = win_q[2'(ea - 16'h8002)];
		end else if (ea >= 16'h8032 && ea <= 16'h8035) begin
			reg_rd = scr_q[3'(ea - 16'h8030)];
		end else begin
			unique case (ea)
				16'h8000: reg_rd = {irq_q, 6'd0};
				16'h8006: reg_rd = line_q;
				16'h8008: reg_rd = req.raster_hcount[9:2];
				16'h8009: reg_rd = req.raster_vcount;
				16'h8010: reg_rd = {req.char_overflow, req.vblank_now, 6'd0};
				16'h8012: reg_rd = {wcn_q[3], 4'd0, wcn_q[2:0]};
				16'h8020: reg_rd = scr_q[0];
				16'h8021: reg_rd = scr_q[1];
				16'h8030: reg_rd = {pri_q, 7'd0};
				16'h8118: reg_rd = cm_q ? bg_q : 8'd0;
				16'h8400: reg_rd = led_q[0];
				16'h8402: reg_rd = led_q[1];
				16'h87e2: reg_rd = cm_q ? {dac_q, 7'd0} : 8'd0;
				16'h87fe: reg_rd = vcrf_pkg::PORT_RSVD_VAL;
				default:  reg_rd = 8'd0;
			endcase
		end
	end

	// source select, in priority order
	vcrf_pkg::src_t src;
	always_comb begin
		priority if (in_col && !coff[0]) src = vcrf_pkg::SRC_COLLO;
		else if (in_col)   src = vcrf_pkg::SRC_COLHI;
		else if (in_spr)   src = vcrf_pkg::SRC_SPR;
		else if (in_coder) src = vcrf_pkg::SRC_CODE;
		else if (in_attr)  src = vcrf_pkg::SRC_ATTR;
		else if (in_char)  src = vcrf_pkg::SRC_CHAR;
		else               src = vcrf_pkg::SRC_REG;
	end

	// stage 1 registers
	vcrf_pkg::src_t src_s1;
	logic [7:0]     reg_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= rd;
		end
	end
	always_ff @(posedge clk) begin
		if (rd) begin
			src_s1 <= src;
			reg_s1 <= reg_rd;
		end
	end

	// output byte
	always_comb begin
		unique case (src_s1)
			vcrf_pkg::SRC_CHAR:  rsp.read_data = char_rd;
			vcrf_pkg::SRC_ATTR:  rsp.read_data = attr_rd;
			vcrf_pkg::SRC_SPR:   rsp.read_data = spr_rd;
			vcrf_pkg::SRC_CODE:  rsp.read_data = {4'd0, code_rd};
			vcrf_pkg::SRC_COLLO: rsp.read_data = collo_rd;
			vcrf_pkg::SRC_COLHI: rsp.read_data = {4'd0, colhi_rd};
			default:             rsp.read_data = reg_s1;
		endcase
	end

endmodule

// ----- sv/vcrf_ram.sv -----
// ----------------------------------------------------------------------------
// vcrf_ram
// Generic single-port write, single-port registered-read RAM.
// ----------------------------------------------------------------------------
module vcrf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
